// ----- rtl/arnt_pkg.sv -----
package arnt_pkg;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 3;
    localparam int ADDR_W  = 64;
    localparam int TIME_W  = 32;
    localparam int ALIVE_W = 31;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] EV_REFRESHED = 3'd1;
    localparam logic [KIND_W-1:0] EV_FULL      = 3'd2;
    localparam logic [KIND_W-1:0] EV_QUERY     = 3'd3;
    localparam logic [KIND_W-1:0] EV_REMOVED   = 3'd4;
    localparam logic [KIND_W-1:0] EV_DONE      = 3'd5;

    // Register map: index is paddr[2]
    localparam logic REG_ALIVE = 1'b0;

    localparam logic [ALIVE_W-1:0] ALIVE_RESET = 31'd7200;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [TIME_W-1:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [ADDR_W-1:0] event_address;
        logic              present;
        logic              last_of_run;
    } t_out_item;

endpackage

// ----- rtl/arnt_front.sv -----
module arnt_front #(
    parameter int ADDRESS_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  arnt_pkg::t_in_item i_in_item,
    output logic               o_work_valid,
    output arnt_pkg::t_in_item o_work,
    input  logic               i_work_pop
);
    import arnt_pkg::*;

    // two-entry work queue
    t_in_item   r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    logic     accept;
    logic     push;
    logic     pop;
    t_in_item work_in;

    assign o_in_stall   = (r_cnt == 2'd2);
    assign accept       = i_in_valid && !o_in_stall;
    // unused command code is taken and dropped here
    assign push         = accept && (i_in_item.command != CMD_NONE);
    assign o_work_valid = (r_cnt != 2'd0);
    assign pop          = i_work_pop && o_work_valid;
    assign o_work       = r_q[r_rd_ptr];

    always_comb begin
        work_in             = i_in_item;
        work_in.address     = ADDR_W'(i_in_item.address[ADDRESS_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= work_in;
        end
    end

endmodule

// ----- rtl/arnt_back.sv -----
module arnt_back #(
    parameter int TABLE_ENTRIES = 5,
    parameter int ADDRESS_BITS  = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_work_valid,
    input  arnt_pkg::t_in_item           i_work,
    output logic                         o_work_pop,
    input  logic [arnt_pkg::ALIVE_W-1:0] i_alive,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output arnt_pkg::t_out_item          o_out_item
);
    import arnt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic                    r_free_found, n_free_found;
    logic [IDX_W-1:0]        r_free_idx, n_free_idx;
    logic [CMD_W-1:0]        r_cmd;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [TIME_W-1:0]       r_now;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [ADDRESS_BITS-1:0]  r_slot_addr [TABLE_ENTRIES];
    logic [TIME_W-1:0]        r_slot_seen [TABLE_ENTRIES];

    logic      r_out_valid;
    t_out_item r_out_item, n_out_item;

    logic                    cur_valid;
    logic [ADDRESS_BITS-1:0] cur_addr;
    logic [TIME_W-1:0]       diff;
    logic                    cur_hit;
    logic                    cur_expired;
    logic                    out_free;
    logic                    load_out;
    logic                    tbl_fill;
    logic                    tbl_touch;
    logic                    tbl_clear;
    logic [IDX_W-1:0]        tbl_idx;

    assign cur_valid   = r_valid[r_idx];
    assign cur_addr    = r_slot_addr[r_idx];
    assign cur_hit     = cur_valid && (cur_addr == r_addr);
    // wrapping signed compare: expired when (seen + alive - now) is negative
    assign diff        = r_slot_seen[r_idx] + {1'b0, i_alive} - r_now;
    assign cur_expired = cur_valid && diff[TIME_W-1];
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_work_pop  = (r_state == S_IDLE) && i_work_valid;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        load_out     = 1'b0;
        tbl_fill     = 1'b0;
        tbl_touch    = 1'b0;
        tbl_clear    = 1'b0;
        tbl_idx      = r_idx;
        n_out_item   = '{event_kind: EV_DONE, event_address: '0,
                         present: 1'b0, last_of_run: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (i_work_valid) begin
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_state      = (i_work.command == CMD_SWEEP) ? S_SWEEP : S_SCAN;
                end
            end
            S_SCAN: begin
                n_out_item.event_address = ADDR_W'(r_addr);
                if (cur_hit || (r_idx == LAST_IDX)) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = S_IDLE;
                        if (r_cmd == CMD_QUERY) begin
                            n_out_item.event_kind = EV_QUERY;
                            n_out_item.present    = cur_hit;
                        end else if (cur_hit) begin
                            n_out_item.event_kind = EV_REFRESHED;
                            tbl_touch             = 1'b1;
                        end else if (r_free_found || !cur_valid) begin
                            n_out_item.event_kind = EV_ADDED;
                            tbl_fill              = 1'b1;
                            tbl_idx               = r_free_found ? r_free_idx : r_idx;
                        end else begin
                            n_out_item.event_kind = EV_FULL;
                        end
                    end
                end else begin
                    if (!cur_valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SWEEP: begin
                n_out_item.event_kind    = EV_REMOVED;
                n_out_item.event_address = ADDR_W'(cur_addr);
                n_out_item.last_of_run   = 1'b0;
                if (!cur_expired || out_free) begin
                    load_out  = cur_expired;
                    tbl_clear = cur_expired;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_free_found <= n_free_found;
            r_free_idx   <= n_free_idx;
            if (tbl_fill) begin
                r_valid[tbl_idx] <= 1'b1;
            end else if (tbl_clear) begin
                r_valid[tbl_idx] <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_work_pop) begin
            r_cmd  <= i_work.command;
            r_addr <= i_work.address[ADDRESS_BITS-1:0];
            r_now  <= i_work.now_seconds;
        end
        if (tbl_fill) begin
            r_slot_addr[tbl_idx] <= r_addr;
        end
        if (tbl_fill || tbl_touch) begin
            r_slot_seen[tbl_idx] <= r_now;
        end
        if (load_out) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_sweep_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_cmd == CMD_SWEEP))
        else $error("sweep walk running for a non-sweep command");

    a_idle_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> ($countones(r_valid) == $past($countones(r_valid))))
        else $error("slot valid bits changed while idle");

    a_removed_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SWEEP) && load_out) |=> !r_valid[$past(r_idx)])
        else $error("removed slot still valid");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && load_out) |=>
            (r_out_item.last_of_run && (r_out_item.event_kind == EV_DONE)))
        else $error("sweep did not close with a final done event");
`endif

endmodule

// ----- rtl/aging_root_neighbor_table_top.sv -----
// Neighbor table with aging. Each input transaction carries a command: add
// (refresh the last-seen time of a matching address, else fill the lowest free
// slot, else report table full), query (one answer with the present flag), or
// sweep (remove every entry whose last-seen time plus alive_seconds lies
// before now, by a wrapping 32-bit signed compare; one "removed" transaction
// per entry in slot order, then "sweep done"). Command code 3 is accepted and
// dropped without output. last_of_run marks the final output transaction of
// each command. Inputs enter a two-entry queue; a sequencer behind it walks
// the table one slot per cycle, pausing when a result must wait on a stalled
// output, with one command in the sequencer at a time. Results leave through
// an output register, so the queue keeps accepting while a result waits.
// alive_seconds (reset 7200) sits at APB byte address 0; write it only while
// the block is idle.
module aging_root_neighbor_table_top #(
    parameter int TABLE_ENTRIES = 5,
    parameter int ADDRESS_BITS  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input transactions
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  arnt_pkg::t_in_item  i_in_item,
    // output transactions
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output arnt_pkg::t_out_item o_out_item,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import arnt_pkg::*;

    logic [ALIVE_W-1:0] r_alive;
    logic               work_valid;
    logic               work_pop;
    t_in_item           work;

    // register write on the access phase; index is paddr[2]
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= ALIVE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ALIVE)) begin
            r_alive <= pwdata[ALIVE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ALIVE) ? {1'b0, r_alive} : 32'd0;

    // front: accept, mask address, drop unused command, queue
    arnt_front #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_work_valid (work_valid),
        .o_work       (work),
        .i_work_pop   (work_pop)
    );

    // back: table and slot-walking sequencer with output register
    arnt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (work_valid),
        .i_work       (work),
        .o_work_pop   (work_pop),
        .i_alive      (r_alive),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule
